### rtl/ipv4dq_pkg.sv
// Shared types and constants for the IPv4 dotted-quad checker.
`default_nettype none

package ipv4dq_pkg;

    // What the previous character of the string was.
    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_DIGIT = 2'd1,
        KIND_DOT   = 2'd2
    } kind_t;

    // One character step handed from the input stage to the scanner.
    typedef struct packed {
        logic       fire;
        logic [7:0] ch;
    } scan_req_t;

    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;

    localparam logic [2:0] SEG_MAX_DIGITS = 3'd4;
    localparam logic [8:0] SEG_MAX_VALUE  = 9'd255;
    localparam logic [8:0] SEG_SAT_VALUE  = 9'd256;
    localparam logic [1:0] DOTS_NEEDED    = 2'd3;
    localparam logic [7:0] LENGTH_RESET   = 8'd15;
    localparam logic [7:0] COUNT_MAX      = 8'd255;

endpackage

`default_nettype wire

### rtl/ipv4dq_scan.sv
// Per-character state update and verdict for the dotted-quad checker.
`default_nettype none

module ipv4dq_scan
    import ipv4dq_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire scan_req_t  req,
    output logic            verdict
);

    logic [7:0] max_length_reg;
    logic [7:0] char_count_reg,     char_count_next;
    logic [1:0] dot_count_reg,      dot_count_next;
    logic [2:0] seg_digits_reg,     seg_digits_next;
    logic [8:0] seg_value_reg,      seg_value_next;
    kind_t      prev_kind_reg,      prev_kind_next;
    logic       error_reg,          error_next;

    logic        is_digit;
    logic        is_dot;
    logic        is_term;
    logic [11:0] seg_scaled;

    assign is_term  = (req.ch == CHAR_NUL);
    assign is_digit = (req.ch >= CHAR_ZERO) && (req.ch <= CHAR_NINE);
    assign is_dot   = (req.ch == CHAR_DOT);

    // value*10 + digit; at most 256*10+9, so 12 bits hold it
    assign seg_scaled = {seg_value_reg, 3'b000} + {2'b00, seg_value_reg, 1'b0}
                      + {8'd0, req.ch[3:0]};

    always_comb begin
        verdict = !error_reg;
        if (prev_kind_reg != KIND_DIGIT) verdict = 1'b0;
        if (dot_count_reg != DOTS_NEEDED) verdict = 1'b0;
        if (seg_value_reg > SEG_MAX_VALUE) verdict = 1'b0;
        if (char_count_reg > max_length_reg) verdict = 1'b0;
    end

    always_comb begin
        char_count_next = char_count_reg;
        dot_count_next  = dot_count_reg;
        seg_digits_next = seg_digits_reg;
        seg_value_next  = seg_value_reg;
        prev_kind_next  = prev_kind_reg;
        error_next      = error_reg;
        if (is_term) begin
            char_count_next = '0;
            dot_count_next  = '0;
            seg_digits_next = '0;
            seg_value_next  = '0;
            prev_kind_next  = KIND_START;
            error_next      = 1'b0;
        end else begin
            if (char_count_reg != COUNT_MAX) char_count_next = char_count_reg + 8'd1;
            if (is_digit) begin
                if (seg_digits_reg <= SEG_MAX_DIGITS) seg_digits_next = seg_digits_reg + 3'd1;
                if (seg_digits_next > SEG_MAX_DIGITS) error_next = 1'b1;
                if (seg_scaled > {3'b000, SEG_SAT_VALUE}) begin
                    seg_value_next = SEG_SAT_VALUE;
                end else begin
                    seg_value_next = seg_scaled[8:0];
                end
                prev_kind_next = KIND_DIGIT;
            end else if (is_dot) begin
                if (prev_kind_reg != KIND_DIGIT) error_next = 1'b1;
                if (dot_count_reg >= DOTS_NEEDED) begin
                    error_next = 1'b1;
                end else begin
                    dot_count_next = dot_count_reg + 2'd1;
                end
                if (seg_value_reg > SEG_MAX_VALUE) error_next = 1'b1;
                seg_digits_next = '0;
                seg_value_next  = '0;
                prev_kind_next  = KIND_DOT;
            end else begin
                // anything else poisons the string; it counts as a digit slot
                error_next     = 1'b1;
                prev_kind_next = KIND_DIGIT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= LENGTH_RESET;
            char_count_reg <= '0;
            dot_count_reg  <= '0;
            seg_digits_reg <= '0;
            seg_value_reg  <= '0;
            prev_kind_reg  <= KIND_START;
            error_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) max_length_reg <= cfg_wr_data;
            if (req.fire) begin
                char_count_reg <= char_count_next;
                dot_count_reg  <= dot_count_next;
                seg_digits_reg <= seg_digits_next;
                seg_value_reg  <= seg_value_next;
                prev_kind_reg  <= prev_kind_next;
                error_reg      <= error_next;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/ipv4_dotted_quad_validator_unit.sv
// Top level: streaming IPv4 dotted-quad string checker.
`default_nettype none

// Checks a NUL-terminated text string, one byte per s_ transfer, and returns one
// m_ transfer per string carrying 1 if it is a valid dotted quad (four segments of
// 1 to 4 digits, each at most 255, three dots, length at most max_length) and 0
// otherwise. Non-terminator bytes produce no output. Every byte passes through an
// input register and then a registered scanner update. A new byte is taken every
// cycle unless a previous verdict is still waiting in the output register when a
// terminator arrives. The user must write max_length through cfg_wr_en/cfg_wr_data
// only while no string is in flight; the block itself does not enforce this.

module ipv4_dotted_quad_validator_unit
    import ipv4dq_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,   // max_length
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,       // [7:0] ch
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata        // [0] valid_res, [7:1] zero
);

    logic       in_valid_reg;
    logic [7:0] in_ch_reg;
    logic       out_valid_reg;
    logic       out_res_reg;
    logic       out_free;
    logic       in_is_term;
    logic       step_fire;
    logic       verdict;
    scan_req_t  req;

    assign in_is_term = (in_ch_reg == CHAR_NUL);
    assign out_free   = !out_valid_reg || m_tready;
    // plain characters never wait; a terminator needs room for its result
    assign step_fire  = in_valid_reg && (!in_is_term || out_free);
    assign s_tready   = !in_valid_reg || step_fire;

    assign req.fire = step_fire;
    assign req.ch   = in_ch_reg;

    ipv4dq_scan u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .verdict     (verdict)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) in_valid_reg <= s_tvalid;
            if (step_fire && in_is_term) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) in_ch_reg <= s_tdata;
        if (step_fire && in_is_term) out_res_reg <= verdict;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_res_reg};

    // a pending result is never overwritten by the next terminator
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !(step_fire && in_is_term))
        else $error("result register overwritten while stalled");

    // every accepted terminator shows up as a result in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_fire && in_is_term) |=> out_valid_reg)
        else $error("terminator transfer lost its result");

    // an empty input register always takes a transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stage stalled while empty");

    // a buffered non-terminator byte is consumed in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !in_is_term) |-> step_fire)
        else $error("plain character held in input stage");

endmodule

`default_nettype wire
